// ===== rtl/ptn_pkg.sv =====
// ptn_pkg: shared types and constants for the pen tilt normaliser.
// Request and result payload structs, operation codes, register indexes, fixed widths
// and the controller state type. No dependencies.
package ptn_pkg;

    localparam int RANGE_W   = 15;
    localparam int TILT_W    = 16;
    localparam int DIV_MAG_W = TILT_W + 1;
    localparam int MAG_W     = 15;
    localparam int COUNT_W   = 16;
    localparam int RAD_W     = 2 * MAG_W;
    localparam int STEPS     = 15;
    localparam int STEP_W    = 4;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [MAG_W-1:0] ONE_Q14 = MAG_W'(16384);

    localparam logic [1:0] OP_TILT_X = 2'd0;
    localparam logic [1:0] OP_TILT_Y = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_IGNORE = 2'd3;

    localparam logic REG_RANGE_X = 1'b0;
    localparam logic REG_RANGE_Y = 1'b1;

    typedef struct packed {
        logic [1:0]               operation;
        logic signed [TILT_W-1:0] tilt_value;
    } ptn_in_t;

    typedef struct packed {
        logic signed [TILT_W-1:0] norm_x;
        logic signed [TILT_W-1:0] norm_y;
        logic [MAG_W-1:0]         magnitude;
        logic [MAG_W-1:0]         change;
        logic [COUNT_W-1:0]       update_count;
    } ptn_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIVIDE,
        ST_SQUARE,
        ST_ROOT_START,
        ST_ROOT,
        ST_DELIVER
    } ptn_state_t;

endpackage

// ===== rtl/pen_tilt_normalizer_top.sv =====
// pen_tilt_normalizer_top: pen tilt normaliser with APB range registers.
// Instantiates four ptn_div lanes and two ptn_sqrt units; uses ptn_pkg.
//
//   channel | ports                          | payload
//   input   | s_valid s_ready s_data         | ptn_in_t  (operation, tilt_value)
//   result  | m_valid m_ready m_data         | ptn_out_t (norms, magnitude, change, count)
//   config  | psel penable pwrite paddr ...  | range_x at 0x0, range_y at 0x4
//
// A tilt sample raises m_valid after, in order: a start state, 15 divider steps, a
// quotient capture, a squaring state, a root start state, 15 root steps, a root
// capture and the output load; all four divisions and both roots run in parallel.
// Tool change and ignored events pass straight to the output load after acceptance.
// One request is in flight at a time; s_ready returns the cycle the result is loaded,
// and a result waiting in the output register holds the controller until taken.
// Reset clears ranges, tilts, held results and the counter.
module pen_tilt_normalizer_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  ptn_pkg::ptn_in_t           s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output ptn_pkg::ptn_out_t          m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ptn_pkg::ADDR_W-1:0] paddr,
    input  logic [ptn_pkg::DATA_W-1:0] pwdata,
    output logic [ptn_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import ptn_pkg::*;

    ptn_state_t state_reg;
    ptn_state_t state_next;

    logic [RANGE_W-1:0] range_x_reg;
    logic [RANGE_W-1:0] range_y_reg;

    logic signed [TILT_W-1:0] raw_x_reg;
    logic signed [TILT_W-1:0] raw_y_reg;
    logic signed [TILT_W-1:0] prev_x_reg;
    logic signed [TILT_W-1:0] prev_y_reg;
    logic signed [TILT_W-1:0] held_norm_x_reg;
    logic signed [TILT_W-1:0] held_norm_y_reg;
    logic [MAG_W-1:0]         held_magnitude_reg;
    logic [MAG_W-1:0]         held_change_reg;
    logic [COUNT_W-1:0]       counter_reg;

    logic [MAG_W-1:0] nx_q_reg;
    logic [MAG_W-1:0] ny_q_reg;
    logic [MAG_W-1:0] dx_q_reg;
    logic [MAG_W-1:0] dy_q_reg;
    logic [RAD_W-1:0] sq_nx_reg;
    logic [RAD_W-1:0] sq_ny_reg;
    logic [RAD_W-1:0] sq_dx_reg;
    logic [RAD_W-1:0] sq_dy_reg;

    logic     m_valid_reg;
    ptn_out_t m_data_reg;

    logic accept;
    logic out_free;
    logic cfg_write;
    logic div_start;
    logic root_start;
    logic div_done;
    logic root_done;

    logic [DIV_MAG_W-1:0] diff_x;
    logic [DIV_MAG_W-1:0] diff_y;
    logic [DIV_MAG_W-1:0] mag_nx;
    logic [DIV_MAG_W-1:0] mag_ny;
    logic [DIV_MAG_W-1:0] mag_dx;
    logic [DIV_MAG_W-1:0] mag_dy;

    logic [3:0]       lane_done;
    logic [MAG_W-1:0] q_nx;
    logic [MAG_W-1:0] q_ny;
    logic [MAG_W-1:0] q_dx;
    logic [MAG_W-1:0] q_dy;
    logic [1:0]       root_lane_done;
    logic [MAG_W-1:0] root_mag;
    logic [MAG_W-1:0] root_chg;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign prdata    = (paddr[2] == REG_RANGE_Y) ? DATA_W'(range_y_reg) : DATA_W'(range_x_reg);
    assign div_done  = &lane_done;
    assign root_done = &root_lane_done;

    always_comb begin
        diff_x = {raw_x_reg[TILT_W-1], raw_x_reg} - {prev_x_reg[TILT_W-1], prev_x_reg};
        diff_y = {raw_y_reg[TILT_W-1], raw_y_reg} - {prev_y_reg[TILT_W-1], prev_y_reg};
        mag_nx = raw_x_reg[TILT_W-1] ? -{1'b1, raw_x_reg} : {1'b0, raw_x_reg};
        mag_ny = raw_y_reg[TILT_W-1] ? -{1'b1, raw_y_reg} : {1'b0, raw_y_reg};
        mag_dx = diff_x[DIV_MAG_W-1] ? -diff_x : diff_x;
        mag_dy = diff_y[DIV_MAG_W-1] ? -diff_y : diff_y;
    end

    ptn_div u_div_nx (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .mag(mag_nx),
        .divisor(range_x_reg), .done(lane_done[0]), .quot(q_nx)
    );
    ptn_div u_div_ny (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .mag(mag_ny),
        .divisor(range_y_reg), .done(lane_done[1]), .quot(q_ny)
    );
    ptn_div u_div_dx (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .mag(mag_dx),
        .divisor(range_x_reg), .done(lane_done[2]), .quot(q_dx)
    );
    ptn_div u_div_dy (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .mag(mag_dy),
        .divisor(range_y_reg), .done(lane_done[3]), .quot(q_dy)
    );

    ptn_sqrt u_sqrt_mag (
        .aclk(aclk), .aresetn(aresetn), .start(root_start),
        .radicand(sq_nx_reg + sq_ny_reg), .done(root_lane_done[0]), .root(root_mag)
    );
    ptn_sqrt u_sqrt_chg (
        .aclk(aclk), .aresetn(aresetn), .start(root_start),
        .radicand(sq_dx_reg + sq_dy_reg), .done(root_lane_done[1]), .root(root_chg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        root_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.operation == OP_TILT_X || s_data.operation == OP_TILT_Y) begin
                        state_next = ST_START;
                    end else begin
                        state_next = ST_DELIVER;
                    end
                end
            end
            ST_START: begin
                div_start  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                state_next = ST_ROOT_START;
            end
            ST_ROOT_START: begin
                root_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (root_done) begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_x_reg <= '0;
            range_y_reg <= '0;
        end else if (cfg_write) begin
            if (paddr[2] == REG_RANGE_X) begin
                range_x_reg <= pwdata[RANGE_W-1:0];
            end else begin
                range_y_reg <= pwdata[RANGE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_x_reg          <= '0;
            raw_y_reg          <= '0;
            prev_x_reg         <= '0;
            prev_y_reg         <= '0;
            held_norm_x_reg    <= '0;
            held_norm_y_reg    <= '0;
            held_magnitude_reg <= '0;
            held_change_reg    <= '0;
            counter_reg        <= '0;
        end else begin
            if (accept) begin
                case (s_data.operation)
                    OP_TILT_X: raw_x_reg <= s_data.tilt_value;
                    OP_TILT_Y: raw_y_reg <= s_data.tilt_value;
                    OP_CLEAR: begin
                        raw_x_reg          <= '0;
                        raw_y_reg          <= '0;
                        prev_x_reg         <= '0;
                        prev_y_reg         <= '0;
                        held_norm_x_reg    <= '0;
                        held_norm_y_reg    <= '0;
                        held_magnitude_reg <= '0;
                        held_change_reg    <= '0;
                        counter_reg        <= counter_reg + 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_START) begin
                prev_x_reg  <= raw_x_reg;
                prev_y_reg  <= raw_y_reg;
                counter_reg <= counter_reg + 1'b1;
            end
            if (state_reg == ST_DIVIDE && div_done) begin
                held_norm_x_reg <= raw_x_reg[TILT_W-1] ? -{1'b0, q_nx} : {1'b0, q_nx};
                held_norm_y_reg <= raw_y_reg[TILT_W-1] ? -{1'b0, q_ny} : {1'b0, q_ny};
            end
            if (state_reg == ST_ROOT && root_done) begin
                held_magnitude_reg <= root_mag;
                held_change_reg    <= root_chg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIVIDE && div_done) begin
            nx_q_reg <= q_nx;
            ny_q_reg <= q_ny;
            dx_q_reg <= q_dx;
            dy_q_reg <= q_dy;
        end
        if (state_reg == ST_SQUARE) begin
            sq_nx_reg <= RAD_W'(nx_q_reg) * RAD_W'(nx_q_reg);
            sq_ny_reg <= RAD_W'(ny_q_reg) * RAD_W'(ny_q_reg);
            sq_dx_reg <= RAD_W'(dx_q_reg) * RAD_W'(dx_q_reg);
            sq_dy_reg <= RAD_W'(dy_q_reg) * RAD_W'(dy_q_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DELIVER && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DELIVER && out_free) begin
            m_data_reg.norm_x       <= held_norm_x_reg;
            m_data_reg.norm_y       <= held_norm_y_reg;
            m_data_reg.magnitude    <= held_magnitude_reg;
            m_data_reg.change       <= held_change_reg;
            m_data_reg.update_count <= counter_reg;
        end
    end

endmodule

// ===== rtl/ptn_div.sv =====
// ptn_div: bit-serial restoring divider, one quotient bit per cycle.
// Gives round(mag * 16384 / divisor) clamped to 16384, zero for a zero divisor.
// Depends on ptn_pkg.
module ptn_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ptn_pkg::DIV_MAG_W-1:0] mag,
    input  logic [ptn_pkg::RANGE_W-1:0]   divisor,
    output logic                          done,
    output logic [ptn_pkg::MAG_W-1:0]     quot
);
    import ptn_pkg::*;

    logic [DIV_MAG_W-1:0] rem_reg;
    logic [DIV_MAG_W-1:0] rem_next;
    logic [DIV_MAG_W-1:0] cand;
    logic [MAG_W-1:0]     quo_reg;
    logic [RANGE_W-1:0]   div_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 zero_reg;
    logic                 sat_reg;
    logic                 ge;
    logic                 rnd;
    logic [MAG_W:0]       rounded;

    always_comb begin
        cand     = (step_reg == '0) ? rem_reg : {rem_reg[DIV_MAG_W-2:0], 1'b0};
        ge       = cand >= {2'b00, div_reg};
        rem_next = ge ? cand - {2'b00, div_reg} : cand;
        rnd      = {1'b0, rem_reg[RANGE_W-1:0], 1'b0} >= {2'b00, div_reg};
        rounded  = {1'b0, quo_reg} + (MAG_W+1)'(rnd);
        if (zero_reg) begin
            quot = '0;
        end else if (sat_reg || rounded > {1'b0, ONE_Q14}) begin
            quot = ONE_Q14;
        end else begin
            quot = rounded[MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= mag;
                div_reg  <= divisor;
                zero_reg <= (divisor == '0);
                sat_reg  <= mag >= {1'b0, divisor, 1'b0};
                quo_reg  <= '0;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[MAG_W-2:0], ge};
                if (step_reg == STEP_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    assign done = done_reg;

endmodule

// ===== rtl/ptn_sqrt.sv =====
// ptn_sqrt: digit-serial square root, two radicand bits per cycle.
// Gives the root rounded to nearest and clamped to 16384.
// Depends on ptn_pkg.
module ptn_sqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [ptn_pkg::RAD_W-1:0] radicand,
    output logic                      done,
    output logic [ptn_pkg::MAG_W-1:0] root
);
    import ptn_pkg::*;

    logic [RAD_W-1:0]  rad_reg;
    logic [MAG_W+2:0]  rem_reg;
    logic [MAG_W+2:0]  rem_next;
    logic [MAG_W+2:0]  cur;
    logic [MAG_W+2:0]  trial;
    logic [MAG_W-1:0]  root_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              ge;
    logic              rnd;
    logic [MAG_W:0]    rounded;

    always_comb begin
        cur      = {rem_reg[MAG_W:0], rad_reg[RAD_W-1:RAD_W-2]};
        trial    = {1'b0, root_reg, 2'b01};
        ge       = cur >= trial;
        rem_next = ge ? cur - trial : cur;
        rnd      = rem_reg > {3'b000, root_reg};
        rounded  = {1'b0, root_reg} + (MAG_W+1)'(rnd);
        root     = (rounded > {1'b0, ONE_Q14}) ? ONE_Q14 : rounded[MAG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                rem_reg  <= rem_next;
                root_reg <= {root_reg[MAG_W-2:0], ge};
                if (step_reg == STEP_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    assign done = done_reg;

endmodule
